>>> hdl/ceiagm_pkg.sv
// Package: shared constants, types and operation codes of the elliptic integral core.
`timescale 1ns / 1ps
package ceiagm_pkg;
   localparam int MOD_W = 31;
   localparam int K_W = 40;
   localparam int E_W = 34;
   localparam int ST_W = 2;
   localparam int MAX_ROUNDS_DEF = 30;
   localparam int OUT_FRAC_BITS_DEF = 32;
   localparam logic [MOD_W-1:0] K_ONE = 31'h4000_0000;
   localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
   localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
   localparam logic [ST_W-1:0] ST_OK = 2'd0;
   localparam logic [ST_W-1:0] ST_UNDEF = 2'd1;
   localparam logic [ST_W-1:0] ST_DOMAIN = 2'd2;

   localparam logic [1:0] OP_SQRT = 2'd0;
   localparam logic [1:0] OP_DIV = 2'd1;
   localparam logic [1:0] OP_SAT = 2'd3;

   typedef struct packed {
      logic         go;
      logic [1:0]   op;
      logic [127:0] num;
      logic [63:0]  den;
   } unit_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] res;
   } unit_rsp_type;
endpackage

>>> hdl/complete_elliptic_integrals_agm_core.sv
// Top level: sequencer for the AGM computation of complete elliptic integrals.
// One start beat yields one response beat: first sqrt(1-k^2), then per AGM round
// (at most MAX_ROUNDS) a convergence check, a square term, a multiply and a
// square root in the shared bit-serial unit; then a final check, a division
// (skipped when a is zero), a multiply, and saturation before the result is
// presented; k >= 1 skips all of these. busy stays high throughout. The
// rsp_valid beat lasts one cycle and cannot be held.
`timescale 1ns / 1ps
module complete_elliptic_integrals_agm_core #(
   parameter int MAX_ROUNDS = ceiagm_pkg::MAX_ROUNDS_DEF,
   parameter int OUT_FRAC_BITS = ceiagm_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ceiagm_pkg::MOD_W-1:0] req_modulus,
   output logic                        rsp_valid,
   output logic [ceiagm_pkg::K_W-1:0]  rsp_first_kind,
   output logic [ceiagm_pkg::E_W-1:0]  rsp_second_kind,
   output logic [ceiagm_pkg::ST_W-1:0] rsp_status
);
   localparam int RW = $clog2(MAX_ROUNDS + 1);
   localparam logic [3:0] S_IDLE = 4'd0, S_B0 = 4'd1, S_B0W = 4'd2, S_CHK = 4'd3,
      S_SQW = 4'd4, S_ABW = 4'd5, S_RTW = 4'd6, S_DIV = 4'd7, S_DVW = 4'd8,
      S_EW = 4'd9, S_OUT = 4'd10, S_EOUT = 4'd11;
   localparam logic [127:0] PI_NUM = {64'd0, ceiagm_pkg::HALF_PI_Q62} << OUT_FRAC_BITS;
   localparam logic [63:0] E_ONE = 64'd1 << OUT_FRAC_BITS;
   localparam logic [63:0] K_MAX = {{(64-ceiagm_pkg::K_W){1'b0}}, {ceiagm_pkg::K_W{1'b1}}};
   localparam logic [65:0] E_MAX = {{(66-ceiagm_pkg::E_W){1'b0}}, {ceiagm_pkg::E_W{1'b1}}};

   logic [3:0]   st_ff;
   logic [RW-1:0] rnd_ff;
   logic [63:0]  a_ff, b_ff, s_ff, an_ff, kq_ff;
   logic [127:0] p_ff;
   logic         rv_ff;
   logic [ceiagm_pkg::K_W-1:0]  fk_ff;
   logic [ceiagm_pkg::E_W-1:0]  sk_ff;
   logic [ceiagm_pkg::ST_W-1:0] stat_ff;

   logic         m_go, m_done;
   logic [63:0]  m_x, m_y;
   logic [127:0] m_p;
   ceiagm_pkg::unit_req_type u_req;
   ceiagm_pkg::unit_rsp_type u_rsp;

   logic [63:0]  d, term, ksq;
   logic [127:0] dsq_sh;
   logic [63:0]  kq_now;

   ceiagm_mul u_mul (.clock, .reset, .go(m_go), .x(m_x), .y(m_y), .done(m_done), .prod(m_p));
   ceiagm_unit u_unit (.clock, .reset, .req(u_req), .rsp(u_rsp));

   assign d = a_ff - b_ff;
   assign ksq = 64'(req_modulus) * 64'(req_modulus);
   assign dsq_sh = m_p >> (7'd64 - 7'(rnd_ff));
   assign term = (dsq_sh[127:64] != 64'd0) ? '1 : dsq_sh[63:0];
   assign kq_now = u_rsp.res;

   always_comb begin
      m_go = 1'b0;
      m_x = d;
      m_y = d;
      u_req = '0;
      unique case (st_ff)
         S_B0: begin
            u_req.go = 1'b1;
            u_req.op = ceiagm_pkg::OP_SQRT;
            u_req.num = {2'b00, s_ff, 62'd0};
         end
         S_CHK: m_go = (d > 64'd1) && (32'(rnd_ff) < MAX_ROUNDS);
         S_SQW: begin
            m_go = m_done;
            m_x = a_ff;
            m_y = b_ff;
         end
         S_ABW: begin
            u_req.go = m_done;
            u_req.op = ceiagm_pkg::OP_SQRT;
            u_req.num = m_p;
         end
         S_DIV: begin
            u_req.go = (a_ff != 64'd0);
            u_req.op = ceiagm_pkg::OP_DIV;
            u_req.num = PI_NUM;
            u_req.den = a_ff;
            m_go = (a_ff == 64'd0);
            m_x = '1;
            m_y = s_ff;
         end
         S_DVW: begin
            m_go = u_rsp.done;
            m_x = kq_now;
            m_y = s_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (start) begin
               if (req_modulus > ceiagm_pkg::K_ONE) begin
                  fk_ff <= '0; sk_ff <= '0; stat_ff <= ceiagm_pkg::ST_DOMAIN;
                  st_ff <= S_OUT;
               end else if (req_modulus == ceiagm_pkg::K_ONE) begin
                  fk_ff <= '0;
                  sk_ff <= (E_ONE > E_MAX[63:0]) ? '1 : E_ONE[ceiagm_pkg::E_W-1:0];
                  stat_ff <= ceiagm_pkg::ST_UNDEF;
                  st_ff <= S_OUT;
               end else begin
                  s_ff <= ceiagm_pkg::Q62_ONE - (ksq << 2);
                  an_ff <= ceiagm_pkg::Q62_ONE - (ksq << 1);
                  a_ff <= ceiagm_pkg::Q62_ONE;
                  rnd_ff <= '0;
                  stat_ff <= ceiagm_pkg::ST_OK;
                  st_ff <= S_B0;
               end
            end
            S_B0: st_ff <= S_B0W;
            S_B0W: if (u_rsp.done) begin
               b_ff <= u_rsp.res;
               s_ff <= an_ff;
               st_ff <= S_CHK;
            end
            S_CHK: st_ff <= m_go ? S_SQW : S_DIV;
            S_SQW: if (m_done) begin
               s_ff <= (term >= s_ff) ? '0 : s_ff - term;
               an_ff <= 64'(({1'b0, a_ff} + {1'b0, b_ff}) >> 1);
               st_ff <= S_ABW;
            end
            S_ABW: if (m_done) st_ff <= S_RTW;
            S_RTW: if (u_rsp.done) begin
               b_ff <= u_rsp.res;
               a_ff <= an_ff;
               rnd_ff <= rnd_ff + 1'b1;
               st_ff <= S_CHK;
            end
            S_DIV: if (a_ff == 64'd0) begin
               kq_ff <= '1;
               st_ff <= S_EW;
            end else st_ff <= S_DVW;
            S_DVW: if (u_rsp.done) begin
               kq_ff <= kq_now;
               st_ff <= S_EW;
            end
            S_EW: if (m_done) begin
               fk_ff <= (kq_ff > K_MAX) ? '1 : kq_ff[ceiagm_pkg::K_W-1:0];
               p_ff <= m_p;
               st_ff <= S_EOUT;
            end
            S_EOUT: begin
               sk_ff <= (p_ff[127:62] > E_MAX) ? '1 : p_ff[62 +: ceiagm_pkg::E_W];
               st_ff <= S_OUT;
            end
            S_OUT: begin
               rv_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (st_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_first_kind = fk_ff;
   assign rsp_second_kind = sk_ff;
   assign rsp_status = stat_ff;

   a_out_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one beat");
   a_busy_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after accept");
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
endmodule

>>> hdl/ceiagm_mul.sv
// Multi-cycle 64x64 multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module ceiagm_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [63:0]  x,
   input  logic [63:0]  y,
   output logic         done,
   output logic [127:0] prod
);
   logic [2:0]   step_ff;
   logic [127:0] acc_ff;
   logic [63:0]  x_ff, y_ff;
   logic [63:0]  pp_ff;
   logic         done_ff;
   logic [1:0]   idx_ff;
   logic         vld_ff;
   logic [1:0]   sel;
   logic [31:0]  xs, ys;
   logic [6:0]   sh;

   always_comb begin
      sel = 2'(step_ff - 3'd1);
      xs = sel[1] ? x_ff[63:32] : x_ff[31:0];
      ys = sel[0] ? y_ff[63:32] : y_ff[31:0];
      sh = {1'b0, idx_ff[1], 5'd0} + {1'b0, idx_ff[0], 5'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         vld_ff <= 1'b0;
         if (go) begin
            step_ff <= 3'd1;
         end else if (step_ff != 3'd0 && step_ff <= 3'd4) begin
            step_ff <= step_ff + 3'd1;
            vld_ff <= 1'b1;
         end else if (step_ff == 3'd5) begin
            step_ff <= 3'd0;
            done_ff <= 1'b1;
         end
      end
      if (go) begin
         x_ff <= x;
         y_ff <= y;
      end
      // add each partial product in the cycle after it is formed
      idx_ff <= sel;
      pp_ff <= 64'(xs) * 64'(ys);
      if (go) acc_ff <= '0;
      else if (vld_ff) acc_ff <= acc_ff + ({64'd0, pp_ff} << sh);
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

>>> hdl/ceiagm_unit.sv
// Shared bit-serial unit: integer square root of 128 bits or saturating 128/64 division.
`timescale 1ns / 1ps
module ceiagm_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  ceiagm_pkg::unit_req_type req,
   output ceiagm_pkg::unit_rsp_type rsp
);
   logic [1:0]   op_ff;
   logic [6:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [127:0] num_ff;
   logic [63:0]  den_ff, q_ff;
   logic [65:0]  rem_ff;
   logic [65:0]  rem_sh, trial;
   logic [127:0] num_sh;

   always_comb begin
      if (op_ff == ceiagm_pkg::OP_SQRT) begin
         rem_sh = {rem_ff[63:0], num_ff[127:126]};
         num_sh = {num_ff[125:0], 2'b00};
         trial = rem_sh - {q_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[64:0], num_ff[127]};
         num_sh = {num_ff[126:0], 1'b0};
         trial = rem_sh - {2'b00, den_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 7'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (req.go) begin
         op_ff <= req.op;
         den_ff <= req.den;
         q_ff <= '0;
         cnt_ff <= 7'd63;
         if (req.op == ceiagm_pkg::OP_SQRT) begin
            rem_ff <= '0;
            num_ff <= req.num;
         end else begin
            rem_ff <= {2'b00, req.num[127:64]};
            num_ff <= {req.num[63:0], 64'd0};
            if (req.num[127:64] >= req.den) begin
               q_ff <= '1;
               cnt_ff <= 7'd0;
               op_ff <= ceiagm_pkg::OP_SAT;
            end
         end
      end else if (busy_ff) begin
         if (op_ff != ceiagm_pkg::OP_SAT) begin
            num_ff <= num_sh;
            if (!trial[65]) begin
               rem_ff <= trial;
               q_ff <= {q_ff[62:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               q_ff <= {q_ff[62:0], 1'b0};
            end
         end
         cnt_ff <= cnt_ff - 7'd1;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.res = q_ff;
endmodule
